### src/bounded_stack_with_keyed_delete_defines.svh
// assertion macros for the bounded stack with keyed delete
`ifndef BOUNDED_STACK_WITH_KEYED_DELETE_DEFINES_SVH
`define BOUNDED_STACK_WITH_KEYED_DELETE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSK_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsk check failed");

// next-cycle implication, clocked on clk, off during reset
`define BSK_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsk check failed");

`endif

### src/bsk_pkg.sv
// shared types and constants for the bounded stack with keyed delete
`timescale 1ns / 1ps
package bsk_pkg;

  localparam int FIELD_W     = 64;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;
  localparam int CAP_W       = 5;
  localparam int DEPTH_DEF   = 16;
  localparam int ENTRY_W_DEF = 64;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index taken from paddr[2]
  localparam logic CFG_IDX_CAP = 1'b0;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LIST  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  data;
    logic                last;
    logic [OCC_W-1:0]    occupancy;
  } out_req_t;

endpackage

### src/bsk_ram.sv
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
module bsk_ram #(
  parameter int DEPTH       = bsk_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = bsk_pkg::ENTRY_W_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [ENTRY_WIDTH-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [ENTRY_WIDTH-1:0] rdata
);

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/bsk_seq.sv
// sequencer: walks the store a word a cycle unless stalled; one compare
`timescale 1ns / 1ps
`include "bounded_stack_with_keyed_delete_defines.svh"
module bsk_seq #(
  parameter int DEPTH       = bsk_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = bsk_pkg::ENTRY_W_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bsk_pkg::in_req_t            in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bsk_pkg::out_req_t           out_req,
  input  logic [bsk_pkg::CAP_W-1:0]   cap_limit,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [ENTRY_WIDTH-1:0]      ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [ENTRY_WIDTH-1:0]      ram_rdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int ZW = (CW > bsk_pkg::CAP_W) ? CW : bsk_pkg::CAP_W;
  localparam int SW = 3;

  localparam logic [SW-1:0] S_IDLE  = 3'd0;
  localparam logic [SW-1:0] S_POP   = 3'd1;
  localparam logic [SW-1:0] S_SRCH  = 3'd2;
  localparam logic [SW-1:0] S_SHIFT = 3'd3;
  localparam logic [SW-1:0] S_LIST  = 3'd4;

  logic [SW-1:0]            state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [ENTRY_WIDTH-1:0]   key_r, key_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bsk_pkg::out_req_t        out_r, out_nxt;

  logic                     out_free;
  logic                     accept;
  logic                     full;
  logic                     match;
  logic [CW-1:0]            cnt_dec;
  logic [AW-1:0]            top_idx;

  function automatic bsk_pkg::out_req_t mk_res(
    input logic [bsk_pkg::STATUS_W-1:0] st,
    input logic [ENTRY_WIDTH-1:0]       d,
    input logic                         lst,
    input logic [CW-1:0]                occ
  );
    bsk_pkg::out_req_t r;
    r.status    = st;
    r.data      = bsk_pkg::FIELD_W'(d);
    r.last      = lst;
    r.occupancy = bsk_pkg::OCC_W'(occ);
    return r;
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && (state_r == S_IDLE) && out_free;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign full     = (ZW'(cnt_r) >= ZW'(cap_limit)) || (ZW'(cnt_r) >= ZW'(DEPTH));
  assign match    = (ram_rdata == key_r);
  assign cnt_dec  = cnt_r - CW'(1);
  assign top_idx  = AW'(cnt_dec);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(cnt_r);
    ram_wdata     = in_req.value[ENTRY_WIDTH-1:0];
    ram_raddr     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_req.value[ENTRY_WIDTH-1:0];
          unique case (in_req.mode)
            bsk_pkg::MODE_PUSH: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt = mk_res(bsk_pkg::ST_FULL, '0, 1'b1, cnt_r);
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
                out_nxt = mk_res(bsk_pkg::ST_OK, '0, 1'b1, cnt_r + CW'(1));
              end
            end
            bsk_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_res(bsk_pkg::ST_EMPTY, '0, 1'b1, cnt_r);
              end else begin
                cnt_nxt   = cnt_dec;
                ram_raddr = top_idx;
                state_nxt = S_POP;
              end
            end
            bsk_pkg::MODE_DEL: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_res(bsk_pkg::ST_EMPTY, '0, 1'b1, cnt_r);
              end else begin
                ram_raddr = top_idx;
                idx_nxt   = top_idx;
                state_nxt = S_SRCH;
              end
            end
            bsk_pkg::MODE_CLEAR: begin
              cnt_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = mk_res(bsk_pkg::ST_OK, '0, 1'b1, '0);
            end
            bsk_pkg::MODE_LIST: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_res(bsk_pkg::ST_EMPTY, '0, 1'b1, cnt_r);
              end else begin
                ram_raddr = top_idx;
                idx_nxt   = top_idx;
                state_nxt = S_LIST;
              end
            end
            default: begin
              // undefined modes leave everything alone
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        out_nxt       = mk_res(bsk_pkg::ST_OK, ram_rdata, 1'b1, cnt_r);
        state_nxt     = S_IDLE;
      end
      S_SRCH: begin
        if (match) begin
          if (CW'(idx_r) + CW'(1) == cnt_r) begin
            cnt_nxt       = cnt_dec;
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res(bsk_pkg::ST_OK, '0, 1'b1, cnt_dec);
            state_nxt     = S_IDLE;
          end else begin
            ram_raddr = AW'(CW'(idx_r) + CW'(1));
            state_nxt = S_SHIFT;
          end
        end else if (idx_r == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(bsk_pkg::ST_NOTFOUND, '0, 1'b1, cnt_r);
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          ram_raddr = idx_r - AW'(1);
        end
      end
      S_SHIFT: begin
        // move the word above down by one place
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (CW'(idx_r) + CW'(2) == cnt_r) begin
          cnt_nxt       = cnt_dec;
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(bsk_pkg::ST_OK, '0, 1'b1, cnt_dec);
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_raddr = AW'(CW'(idx_r) + CW'(2));
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(bsk_pkg::ST_OK, ram_rdata, idx_r == '0, cnt_r);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            ram_raddr = idx_r - AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  `BSK_ASSERT_IMPL(a_cnt_bound, 1'b1, ZW'(cnt_r) <= ZW'(DEPTH))
  `BSK_ASSERT_IMPL(a_shift_range, state_r == S_SHIFT, CW'(idx_r) + CW'(2) <= cnt_r)
  `BSK_ASSERT_NEXT(a_push_grows, accept && in_req.mode == bsk_pkg::MODE_PUSH && !full, cnt_r == $past(cnt_r) + CW'(1))
  `BSK_ASSERT_NEXT(a_busy_no_grow, state_r != S_IDLE, cnt_r <= $past(cnt_r))

endmodule

### src/bounded_stack_with_keyed_delete.sv
// Bounded LIFO stack of entry words with push, pop, keyed delete, clear and list.
// Requests enter on in_valid/in_stall with in_req {mode, value}; results leave on
// out_valid/out_stall with out_req {status, data, last, occupancy}.
// One request is in work at a time; in_stall stays high until it is finished.
// Push and clear: result in the cycle after accept, when a next request may enter.
// Pop: the registered read of the entry store, then the registered result.
// Delete: entries are searched one at a time from the top, then each entry above
// the match is moved down one place; the single store read port sets the pace.
// List: one result per held entry, top first, last set on the bottom one; the walk
// waits while out_stall holds the output register.
// A result waits in the output register while out_stall is high; no new request
// is taken until that register can be loaded.
// capacity_limit sits at byte address 0 of the APB-style port (pready always high);
// writes are for idle periods only. Reset (rst_n low, synchronous) empties the stack
// and sets capacity_limit to 16; the entry store itself is not cleared.
`timescale 1ns / 1ps
module bounded_stack_with_keyed_delete #(
  parameter int DEPTH       = bsk_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = bsk_pkg::ENTRY_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bsk_pkg::in_req_t                 in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bsk_pkg::out_req_t                out_req,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsk_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bsk_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bsk_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bsk_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic                      cfg_wr;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ENTRY_WIDTH-1:0]    ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [ENTRY_WIDTH-1:0]    ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr && (paddr[2] == bsk_pkg::CFG_IDX_CAP)) begin
      cap_nxt = pwdata[bsk_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bsk_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata = (paddr[2] == bsk_pkg::CFG_IDX_CAP) ?
                  bsk_pkg::CFG_DATA_W'(cap_r) : '0;

  bsk_seq #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cap_limit (cap_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bsk_ram #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
